FILE: hdl/lfr_pkg.sv
// Shared types, constants and the microprogram of the lowpass fractional resampler.
// Used by lfr_sequencer, lfr_datapath and lowpass_fractional_resampler_core.
// Depends on nothing else.
`default_nettype none

package lfr_pkg;

  localparam int PHASE_RES_BITS_DEF = 30;
  localparam int CFG_DATA_W         = 32;
  localparam int CFG_INDEX_W        = 2;
  localparam int STEP_W             = 4;

  localparam logic [16:0] ALPHA_ONE   = 17'h10000;
  localparam logic [31:0] INC_RESET   = 32'h4000_0000;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INC    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEREO = 2'd2;

  typedef logic [STEP_W-1:0] step_t;

  // Microprogram addresses.
  localparam step_t S_WAIT   = 4'd0;
  localparam step_t S_FILT_L = 4'd1;
  localparam step_t S_FILT_R = 4'd2;
  localparam step_t S_WB_R   = 4'd3;
  localparam step_t S_TEST   = 4'd4;
  localparam step_t S_DIV0   = 4'd5;
  localparam step_t S_DIVN   = 4'd6;
  localparam step_t S_INT_L  = 4'd7;
  localparam step_t S_INT_R  = 4'd8;
  localparam step_t S_WB_OR  = 4'd9;
  localparam step_t S_EMIT   = 4'd10;
  localparam step_t S_LOOP   = 4'd11;
  localparam step_t S_COMMIT = 4'd12;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_IN_IDLE,
    C_OUT_BUSY,
    C_PHASE_LE,
    C_CNT_NZ
  } cond_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FILT_L,
    MUL_FILT_R,
    MUL_INT_L,
    MUL_INT_R
  } mul_op_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_CUR_L,
    WB_CUR_R,
    WB_RES_L,
    WB_RES_R
  } wb_dst_t;

  typedef struct packed {
    cond_t   cond;
    step_t   target;
    mul_op_t mul_op;
    wb_dst_t wb_dst;
    logic    take;
    logic    test;
    logic    div_first;
    logic    div_step;
    logic    emit;
    logic    commit;
  } ctrl_word_t;

  typedef struct packed {
    logic in_idle;
    logic out_busy;
    logic phase_le;
    logic cnt_nz;
  } status_t;

  typedef struct packed {
    logic [16:0] alpha;
    logic [31:0] inc;
    logic        stereo;
  } cfg_t;

  // Control store: one word per microprogram step.
  function automatic ctrl_word_t prog_rom(input step_t step);
    ctrl_word_t cw;
    cw = '{cond: C_NEXT, target: S_WAIT, mul_op: MUL_NONE, wb_dst: WB_NONE,
           take: 1'b0, test: 1'b0, div_first: 1'b0, div_step: 1'b0,
           emit: 1'b0, commit: 1'b0};
    unique case (step)
      S_WAIT: begin
        cw.take   = 1'b1;
        cw.cond   = C_IN_IDLE;
        cw.target = S_WAIT;
      end
      S_FILT_L: cw.mul_op = MUL_FILT_L;
      S_FILT_R: begin
        cw.wb_dst = WB_CUR_L;
        cw.mul_op = MUL_FILT_R;
      end
      S_WB_R:   cw.wb_dst = WB_CUR_R;
      S_TEST: begin
        cw.test   = 1'b1;
        cw.cond   = C_PHASE_LE;
        cw.target = S_COMMIT;
      end
      S_DIV0:   cw.div_first = 1'b1;
      S_DIVN: begin
        cw.div_step = 1'b1;
        cw.cond     = C_CNT_NZ;
        cw.target   = S_DIVN;
      end
      S_INT_L:  cw.mul_op = MUL_INT_L;
      S_INT_R: begin
        cw.wb_dst = WB_RES_L;
        cw.mul_op = MUL_INT_R;
      end
      S_WB_OR:  cw.wb_dst = WB_RES_R;
      S_EMIT: begin
        cw.emit   = 1'b1;
        cw.cond   = C_OUT_BUSY;
        cw.target = S_EMIT;
      end
      S_LOOP: begin
        cw.cond   = C_ALWAYS;
        cw.target = S_TEST;
      end
      S_COMMIT: begin
        cw.commit = 1'b1;
        cw.cond   = C_ALWAYS;
        cw.target = S_WAIT;
      end
      default: begin
        cw.cond   = C_ALWAYS;
        cw.target = S_WAIT;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lowpass_fractional_resampler_core.sv
// Top level of the lowpass fractional resampler: configuration registers,
// microprogram sequencer and datapath. Depends on lfr_pkg, lfr_sequencer, lfr_datapath.
//
// Input words (left_in, right_in) arrive on a valid/ready channel; each passes
// through a one-pole lowpass and advances the phase accumulator, producing zero,
// one or two interpolated output words (left_out, right_out, last_of_run) on a
// valid/ready output channel. last_of_run marks the final word caused by an input.
// Timing is set by the microprogram and its shared 17-step restoring divider.
// The block takes one input word at a time; in_ready is high only while the sequencer
// waits at its first step. A single output register holds a finished word, so the
// sequencer carries on with the next word's filtering and division while the receiver
// stalls; it waits only when it must load a new word into the still occupied output
// register. Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and the user must make them while the block is idle, as the block does not enforce it.
// Reset clears the phase and the stored samples and loads alpha = 1.0, increment = 2^30
// and stereo mode.
`default_nettype none

module lowpass_fractional_resampler_core
  import lfr_pkg::*;
#(
  parameter int PHASE_RES_BITS = PHASE_RES_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic signed [15:0]     left_in,
  input  wire logic signed [15:0]     right_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [15:0]          left_out,
  output logic signed [15:0]          right_out,
  output logic                        last_of_run,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  ctrl_word_t cw;
  status_t    status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha  <= ALPHA_ONE;
      cfg.inc    <= INC_RESET;
      cfg.stereo <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ALPHA:  cfg.alpha  <= cfg_data[16:0];
        REG_INC:    cfg.inc    <= cfg_data[31:0];
        REG_STEREO: cfg.stereo <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = cw.take;

  lfr_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cw     (cw)
  );

  lfr_datapath #(
    .PHASE_RES_BITS (PHASE_RES_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cw          (cw),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .left_in     (left_in),
    .right_in    (right_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_out    (left_out),
    .right_out   (right_out),
    .last_of_run (last_of_run),
    .status      (status)
  );

endmodule

`default_nettype wire

FILE: hdl/lfr_sequencer.sv
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
// Depends on lfr_pkg.
`default_nettype none

module lfr_sequencer
  import lfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire status_t    status,
  output ctrl_word_t      cw
);

  step_t step;
  step_t step_next;
  logic  jump;

  assign cw = prog_rom(step);

  always_comb begin
    unique case (cw.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_IN_IDLE:  jump = status.in_idle;
      C_OUT_BUSY: jump = status.out_busy;
      C_PHASE_LE: jump = status.phase_le;
      C_CNT_NZ:   jump = status.cnt_nz;
      default:    jump = 1'b1;
    endcase
    step_next = jump ? cw.target : step_t'(step + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lfr_datapath.sv
// Datapath of the resampler: filter and interpolation multiplier, restoring divider,
// phase accumulator, sample state and the output register. Driven by lfr_sequencer.
// Depends on lfr_pkg.
`default_nettype none

module lfr_datapath
  import lfr_pkg::*;
#(
  parameter int PHASE_RES_BITS = PHASE_RES_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_word_t         cw,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] left_in,
  input  wire logic signed [15:0] right_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      left_out,
  output logic signed [15:0]      right_out,
  output logic                    last_of_run,
  output status_t                 status
);

  localparam int PW = PHASE_RES_BITS + 2;
  localparam logic [PW-1:0] Thresh   = PW'(1) << PHASE_RES_BITS;
  localparam logic [PW-1:0] MaxInc   = PW'(1) << (PHASE_RES_BITS + 1);
  localparam logic [31:0]   MaxInc32 = 32'(1) << (PHASE_RES_BITS + 1);

  // Configuration after saturation.
  logic [16:0]   alpha_sat;
  logic [PW-1:0] inc_sat;

  // Sample and phase state.
  logic signed [15:0] x_l, x_r;
  logic signed [15:0] prev_l, prev_r;
  logic signed [15:0] cur_l, cur_r;
  logic signed [15:0] res_l, res_r;
  logic [PW-1:0]      phase_accum;
  logic [PW-1:0]      phase;
  logic               phase_gt;

  // Divider.
  logic [PW-1:0] rem;
  logic [PW-1:0] rem_dbl;
  logic [16:0]   quot;
  logic [3:0]    cnt;
  logic          bit0, bitn;
  logic [16:0]   weight_sat;

  // Multiplier.
  logic signed [15:0] mul_a, mul_b;
  logic [16:0]        mul_w;
  logic signed [16:0] diff;
  logic signed [17:0] wgt;
  logic signed [34:0] prod;
  logic signed [34:0] prod_q;
  logic signed [15:0] base_q;
  logic signed [18:0] blend_sum;
  logic signed [15:0] blend_res;

  logic accept;
  logic out_busy;
  logic out_load;

  always_comb begin
    alpha_sat = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
    if (cfg.inc == 32'd0) begin
      inc_sat = PW'(1);
    end else if (cfg.inc > MaxInc32) begin
      inc_sat = MaxInc;
    end else begin
      inc_sat = PW'(cfg.inc);
    end
  end

  assign accept   = cw.take && in_valid;
  assign phase_gt = phase > Thresh;
  assign out_busy = out_valid && !out_ready;
  assign out_load = cw.emit && !out_busy;

  assign status.in_idle  = !in_valid;
  assign status.out_busy = out_busy;
  assign status.phase_le = !phase_gt;
  assign status.cnt_nz   = cnt != 4'd0;

  // The remainder stays below the increment, so the doubled value cannot overflow.
  assign rem_dbl    = {rem[PW-2:0], 1'b0};
  assign bit0       = rem >= inc_sat;
  assign bitn       = rem_dbl >= inc_sat;
  assign weight_sat = (quot > ALPHA_ONE) ? ALPHA_ONE : quot;

  always_comb begin
    mul_a = x_l;
    mul_b = prev_l;
    mul_w = alpha_sat;
    case (cw.mul_op)
      MUL_FILT_R: begin
        mul_a = x_r;
        mul_b = prev_r;
      end
      MUL_INT_L: begin
        mul_a = prev_l;
        mul_b = cur_l;
        mul_w = weight_sat;
      end
      MUL_INT_R: begin
        mul_a = prev_r;
        mul_b = cur_r;
        mul_w = weight_sat;
      end
      default: ;
    endcase
  end

  // a*w + b*(1-w) is computed as b + (a-b)*w, floored by the arithmetic shift.
  assign diff      = $signed({mul_a[15], mul_a}) - $signed({mul_b[15], mul_b});
  assign wgt       = $signed({1'b0, mul_w});
  assign prod      = diff * wgt;
  assign blend_sum = $signed({{3{base_q[15]}}, base_q}) + $signed(prod_q[34:16]);
  assign blend_res = blend_sum[15:0];

  always_ff @(posedge clk) begin
    prod_q <= prod;
    base_q <= mul_b;

    if (accept) begin
      x_l   <= left_in;
      x_r   <= right_in;
      phase <= phase_accum + inc_sat;
    end

    case (cw.wb_dst)
      WB_CUR_L: cur_l <= blend_res;
      WB_CUR_R: cur_r <= blend_res;
      WB_RES_L: res_l <= blend_res;
      WB_RES_R: res_r <= cfg.stereo ? blend_res : 16'sd0;
      default: ;
    endcase

    if (cw.test && phase_gt) begin
      phase <= phase - Thresh;
      rem   <= phase - Thresh;
    end

    if (cw.div_first) begin
      rem  <= bit0 ? rem - inc_sat : rem;
      quot <= {16'd0, bit0};
      cnt  <= 4'd15;
    end else if (cw.div_step) begin
      rem  <= bitn ? rem_dbl - inc_sat : rem_dbl;
      quot <= {quot[15:0], bitn};
      cnt  <= cnt - 4'd1;
    end

    if (out_load) begin
      left_out    <= res_l;
      right_out   <= res_r;
      last_of_run <= !phase_gt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      phase_accum <= '0;
      prev_l      <= 16'sd0;
      prev_r      <= 16'sd0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cw.commit) begin
        phase_accum <= phase;
        prev_l      <= cur_l;
        if (cfg.stereo) begin
          prev_r <= cur_r;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/lowpass_fractional_resampler_core_tb.sv
// Self-checking testbench for lowpass_fractional_resampler_core: a behavioural
// lowpass/resampler predictor checks every output word under random flow control.
// Depends on lfr_pkg and the RTL of the core.

module lowpass_fractional_resampler_core_tb
  import lfr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_BITS  = PHASE_RES_BITS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYC  = 64;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } in_word_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } out_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [15:0]      left_in = '0;
  logic signed [15:0]      right_in = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [15:0]      left_out;
  logic signed [15:0]      right_out;
  logic                    last_of_run;
  logic                    cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  lowpass_fractional_resampler_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .left_in    (left_in),
    .right_in   (right_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .left_out   (left_out),
    .right_out  (right_out),
    .last_of_run(last_of_run),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor state and its copy of the registers.
  logic [16:0] alpha_reg  = ALPHA_ONE;
  logic [31:0] inc_reg    = INC_RESET;
  logic        stereo_reg = 1'b1;
  logic [31:0] phase_acc  = '0;
  int          pred_prev_l = 0;
  int          pred_prev_r = 0;

  in_word_t  sample_q[$];
  out_word_t resampled_q[$];

  int  words_pushed = 0;
  int  words_taken  = 0;
  int  errors       = 0;
  bit  in_acc       = 1'b0;
  bit  src_idle_en  = 1'b1;
  bit  sink_idle_en = 1'b1;
  int  src_gap      = 0;
  int  hold_left    = 0;
  int  hold_req     = 0;
  int  hold_seen    = 0;
  int  quiet_cycles = 0;

  // Weighted mix of two samples, floored: (a*wa + b*(1-wa)) >> 16.
  function automatic int mix(input int a, input int b, input longint wa);
    longint t;
    t = longint'(a) * wa + longint'(b) * (longint'(65536) - wa);
    return int'(t >>> 16);
  endfunction

  task automatic resample_step(input logic signed [15:0] l_in, input logic signed [15:0] r_in);
    logic [16:0] alpha_eff;
    logic [63:0] inc_eff;
    logic [63:0] thresh;
    logic [63:0] ph;
    logic [63:0] w;
    int          cur_l;
    int          cur_r;
    int          n;
    out_word_t   ow;
    thresh    = 64'd1 << PHASE_BITS;
    alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    inc_eff   = {32'd0, inc_reg};
    if (inc_eff == 0) inc_eff = 64'd1;
    if (inc_eff > (thresh << 1)) inc_eff = thresh << 1;
    cur_l = mix(int'(l_in), pred_prev_l, longint'(alpha_eff));
    cur_r = stereo_reg ? mix(int'(r_in), pred_prev_r, longint'(alpha_eff)) : 0;
    ph = {32'd0, phase_acc} + inc_eff;
    n  = 0;
    while (ph > thresh && n < 2) begin
      ph = ph - thresh;
      w  = (ph << 16) / inc_eff;
      if (w > 64'd65536) w = 64'd65536;
      ow.left  = 16'(mix(pred_prev_l, cur_l, longint'(w)));
      ow.right = stereo_reg ? 16'(mix(pred_prev_r, cur_r, longint'(w))) : 16'sd0;
      ow.last  = 1'b0;
      resampled_q.push_back(ow);
      n++;
    end
    if (n > 0) resampled_q[resampled_q.size()-1].last = 1'b1;
    phase_acc = ph[31:0];
    pred_prev_l = cur_l;
    if (stereo_reg) pred_prev_r = cur_r;
  endtask

  // Sampling and checking at the rising edge.
  always @(posedge clk) begin
    out_word_t ow;
    in_acc <= in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (resampled_q.size() == 0) begin
          $error("unexpected output word: left_out %0d right_out %0d last_of_run %0b",
                 left_out, right_out, last_of_run);
          errors++;
        end else begin
          ow = resampled_q.pop_front();
          if (left_out !== ow.left) begin
            $error("left_out: expected %0d, got %0d", ow.left, left_out);
            errors++;
          end
          if (right_out !== ow.right) begin
            $error("right_out: expected %0d, got %0d", ow.right, right_out);
            errors++;
          end
          if (last_of_run !== ow.last) begin
            $error("last_of_run: expected %0b, got %0b", ow.last, last_of_run);
            errors++;
          end
        end
      end
      // Outputs seen in this cycle belong to earlier words, so predict afterwards.
      if (in_valid && in_ready) begin
        words_taken++;
        resample_step(left_in, right_in);
      end
    end
  end

  // Source side: holds each word until it is taken, with random gaps between words.
  always @(negedge clk) begin
    in_word_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (src_gap != 0) begin
        src_gap  <= src_gap - 1;
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        nxt = sample_q.pop_front();
        in_valid <= 1'b1;
        left_in  <= nxt.left;
        right_in <= nxt.right;
        if (src_idle_en && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Sink side: random stall bursts, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 500;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("lowpass_fractional_resampler_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer(input logic [15:0] l, input logic [15:0] r);
    in_word_t wd;
    wd.left  = l;
    wd.right = r;
    sample_q.push_back(wd);
    words_pushed++;
  endtask

  function automatic logic [15:0] edge_or_random();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_batch(input int n, input bit src_idle, input bit sink_idle);
    @(posedge clk);
    src_idle_en  = src_idle;
    sink_idle_en = sink_idle;
    repeat (n) offer(edge_or_random(), edge_or_random());
  endtask

  // Waits until every word is taken and answered, then lets a word that yields
  // nothing run through the pipeline before the registers may change.
  task automatic settle();
    do @(negedge clk); while (words_taken != words_pushed || resampled_q.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ALPHA:  alpha_reg  = val[16:0];
      REG_INC:    inc_reg    = val;
      REG_STEREO: stereo_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [31:0] a, input logic [31:0] inc, input logic st);
    write_reg(REG_ALPHA, a);
    write_reg(REG_INC, inc);
    write_reg(REG_STEREO, {31'd0, st});
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [31:0] a_val;
    logic [31:0] i_val;
    int          p;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: the first word lands the phase exactly on the threshold,
    // after which each word yields one output at full weight on the older sample.
    @(posedge clk);
    offer(16'h7FFF, 16'h8000);
    offer(16'h8000, 16'h7FFF);
    offer(16'h0000, 16'h0000);
    offer(16'hFFFF, 16'hFFFF);
    offer(16'h7FFF, 16'h7FFF);
    offer(16'h8000, 16'h8000);
    offer(16'h0001, 16'hFFFE);
    offer(16'hFFFF, 16'h5555);
    settle();

    // Alpha and increment above their limits saturate; mono mode ignores the right input.
    load_regs(32'h0001_FFFF, 32'hFFFF_FFFF, 1'b0);
    @(posedge clk);
    offer(16'h7FFF, 16'h7FFF);
    offer(16'h8000, 16'h8000);
    offer(16'h1234, 16'hAAAA);
    offer(16'hFFFF, 16'h0001);
    offer(16'h8000, 16'h7FFF);
    offer(16'h7FFF, 16'h8000);
    settle();

    // A zero increment counts as one and alpha zero holds the filter still.
    load_regs(32'd0, 32'd0, 1'b1);
    @(posedge clk);
    offer(16'h7FFF, 16'h8000);
    offer(16'h8000, 16'h7FFF);
    offer(16'h4321, 16'hCDEF);
    offer(16'hFFFF, 16'h0000);
    settle();

    load_regs(32'd65535, 32'h3000_3039, 1'b1);
    @(posedge clk);
    offer(16'h7FFF, 16'h8000);
    offer(16'h8000, 16'h7FFF);
    offer(16'h7FFF, 16'h7FFF);
    offer(16'h0000, 16'hFFFF);
    offer(16'h8000, 16'h8000);
    offer(16'h2AAA, 16'hD555);
    settle();

    for (p = 0; p < 9; p++) begin
      case ($urandom_range(0, 9))
        0, 1:    a_val = 32'd65536;
        2:       a_val = 32'd0;
        3:       a_val = $urandom_range(65537, 131071);
        default: a_val = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 9))
        0:       i_val = 32'h8000_0000;
        1:       i_val = $urandom_range(32'h8000_0001, 32'hFFFF_FFFF);
        2:       i_val = $urandom_range(0, 1) ? 32'h4000_0000 : 32'h1000_0000;
        default: i_val = $urandom_range(32'h0800_0000, 32'h8000_0000);
      endcase
      load_regs(a_val, i_val, 1'($urandom_range(0, 1)));
      if (p == 3) begin
        // Long sink hold-off while the source keeps offering words.
        @(posedge clk);
        hold_req++;
      end
      if (p == 8) random_batch(70, 1'b0, 1'b0);
      else random_batch(70, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
      settle();
    end

    if (errors == 0) $display("lowpass_fractional_resampler_core verification clean");
    else $display("lowpass_fractional_resampler_core verification failed");
    $finish;
  end

endmodule

FILE: files.f
hdl/lfr_pkg.sv
hdl/lfr_sequencer.sv
hdl/lfr_datapath.sv
hdl/lowpass_fractional_resampler_core.sv
tb/lowpass_fractional_resampler_core_tb.sv
